FILE: rtl/core/bpa_pkg.sv
// bpa_pkg: shared types, codes and defaults for the buddy page allocator
// depends on nothing; imported by every module under rtl/core
`default_nettype none

package bpa_pkg;

    localparam int LEVELS_DEF     = 8;
    localparam int TOP_BLOCKS_DEF = 16;
    localparam int PAGE_SHIFT_DEF = 12;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_BAD   = 2'd2
    } stat_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CHECK,
        ST_SRCH,
        ST_POPRD,
        ST_POPWR,
        ST_TGRD,
        ST_TGWR,
        ST_PUSH,
        ST_PUSH2,
        ST_ULRD,
        ST_ULWR1,
        ST_ULWR2,
        ST_DESC,
        ST_FPOS,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic        op;
        logic [4:0]  order;
        logic [31:0] address;
    } in_word_t;

    typedef struct packed {
        logic [31:0] block_address;
        logic [1:0]  status;
    } out_word_t;

    typedef struct packed {
        logic [31:0] addr;
        logic        add_base;
        stat_t       status;
    } res_t;

    typedef struct packed {
        logic next_we;
        logic prev_we;
        logic pair_we;
        logic pair_wdata;
    } mem_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/buddy_page_allocator.sv
// buddy_page_allocator: top level with base register and output word register
// depends on bpa_pkg, bpa_ctrl, bpa_mem
// one word at a time, input reopens after the result is registered
// reset: a clearing sweep clears the pair bits and chains the top order;
// no input word is taken until it ends
`default_nettype none

module buddy_page_allocator #(
    parameter int LEVELS     = bpa_pkg::LEVELS_DEF,
    parameter int TOP_BLOCKS = bpa_pkg::TOP_BLOCKS_DEF,
    parameter int PAGE_SHIFT = bpa_pkg::PAGE_SHIFT_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_we,
    input  wire logic [31:0]         cfg_wdata,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire bpa_pkg::in_word_t   s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output bpa_pkg::out_word_t       m_data
);
    import bpa_pkg::*;

    localparam int NODES = TOP_BLOCKS * ((1 << LEVELS) - 1);
    localparam int PAIRS = NODES / 2;
    localparam int NW    = $clog2(NODES);
    localparam int PAW   = $clog2(PAIRS);
    localparam int LW    = $clog2((TOP_BLOCKS << (LEVELS - 1)) + 1);

    logic [31:0]    memory_base_reg;
    logic           m_valid_reg;
    out_word_t      m_data_reg;
    logic           res_valid, res_ready;
    res_t           res;
    logic [NW-1:0]  node_addr;
    logic [PAW-1:0] pair_addr;
    logic [LW-1:0]  next_wdata, prev_wdata, next_rdata, prev_rdata;
    logic           pair_rdata;
    mem_ctl_t       ctl;

    assign res_ready = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    bpa_ctrl #(
        .LEVELS(LEVELS), .TOP_BLOCKS(TOP_BLOCKS), .PAGE_SHIFT(PAGE_SHIFT),
        .PAIRS(PAIRS), .NW(NW), .PAW(PAW), .LW(LW)
    ) u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .memory_base(memory_base_reg),
        .res_valid(res_valid), .res_ready(res_ready), .res(res),
        .node_addr(node_addr), .pair_addr(pair_addr),
        .next_wdata(next_wdata), .prev_wdata(prev_wdata), .ctl(ctl),
        .next_rdata(next_rdata), .prev_rdata(prev_rdata), .pair_rdata(pair_rdata)
    );

    bpa_mem #(
        .NODES(NODES), .PAIRS(PAIRS), .NW(NW), .PAW(PAW), .LW(LW)
    ) u_mem (
        .aclk(aclk), .node_addr(node_addr), .pair_addr(pair_addr),
        .next_wdata(next_wdata), .prev_wdata(prev_wdata), .ctl(ctl),
        .next_rdata(next_rdata), .prev_rdata(prev_rdata), .pair_rdata(pair_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            memory_base_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                memory_base_reg <= cfg_wdata;
            end
            if (res_valid && res_ready) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_data_reg.block_address <= res.addr + (res.add_base ? memory_base_reg : 32'd0);
            m_data_reg.status        <= res.status;
        end
    end

    // block goes busy after taking a word
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while busy");

    // sweep after reset keeps the input closed
    assert property (@(posedge aclk) !aresetn |=> !s_ready)
        else $error("input open during clearing sweep");

    // failed words carry a zero address; free words do too, though this checks only failed ones
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != STAT_OK) |-> (m_data.block_address == 32'd0))
        else $error("nonzero address on error word");

    // a result is loaded only into a free or draining output slot
    assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && m_valid && !m_ready) |=> res_valid)
        else $error("result dropped while output stalled");

endmodule

`default_nettype wire

FILE: rtl/core/bpa_mem.sv
// bpa_mem: next/prev link memories and the buddy pair bit memory
// depends on bpa_pkg for the control struct
`default_nettype none

module bpa_mem #(
    parameter int NODES = 4080,
    parameter int PAIRS = 2040,
    parameter int NW    = 12,
    parameter int PAW   = 11,
    parameter int LW    = 12
) (
    input  wire logic               aclk,
    input  wire logic [NW-1:0]      node_addr,
    input  wire logic [PAW-1:0]     pair_addr,
    input  wire logic [LW-1:0]      next_wdata,
    input  wire logic [LW-1:0]      prev_wdata,
    input  wire bpa_pkg::mem_ctl_t  ctl,
    output logic      [LW-1:0]      next_rdata,
    output logic      [LW-1:0]      prev_rdata,
    output logic                    pair_rdata
);
    import bpa_pkg::*;

    logic [LW-1:0] next_mem [NODES];
    logic [LW-1:0] prev_mem [NODES];
    logic          pair_mem [PAIRS];

    always_ff @(posedge aclk) begin
        if (ctl.next_we) begin
            next_mem[node_addr] <= next_wdata;
        end
        next_rdata <= next_mem[node_addr];
    end

    always_ff @(posedge aclk) begin
        if (ctl.prev_we) begin
            prev_mem[node_addr] <= prev_wdata;
        end
        prev_rdata <= prev_mem[node_addr];
    end

    always_ff @(posedge aclk) begin
        if (ctl.pair_we) begin
            pair_mem[pair_addr] <= ctl.pair_wdata;
        end
        pair_rdata <= pair_mem[pair_addr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/bpa_ctrl.sv
// bpa_ctrl: sequencer, list heads and shared address adder of the allocator
// depends on bpa_pkg; drives the memories in bpa_mem
`default_nettype none

module bpa_ctrl #(
    parameter int LEVELS     = 8,
    parameter int TOP_BLOCKS = 16,
    parameter int PAGE_SHIFT = 12,
    parameter int PAIRS      = 2040,
    parameter int NW         = 12,
    parameter int PAW        = 11,
    parameter int LW         = 12
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire bpa_pkg::in_word_t  s_data,
    input  wire logic [31:0]        memory_base,
    output logic                    res_valid,
    input  wire logic               res_ready,
    output bpa_pkg::res_t           res,
    output logic      [NW-1:0]      node_addr,
    output logic      [PAW-1:0]     pair_addr,
    output logic      [LW-1:0]      next_wdata,
    output logic      [LW-1:0]      prev_wdata,
    output bpa_pkg::mem_ctl_t       ctl,
    input  wire logic [LW-1:0]      next_rdata,
    input  wire logic [LW-1:0]      prev_rdata,
    input  wire logic               pair_rdata
);
    import bpa_pkg::*;

    localparam int KW = $clog2(LEVELS);
    localparam logic [31:0] TB32  = 32'(TOP_BLOCKS);
    localparam logic [31:0] TBL32 = 32'(TOP_BLOCKS) << LEVELS;
    localparam logic [NW-1:0] TOP_BASE = NW'(TBL32 - (TB32 << 1));
    localparam logic [KW-1:0] K_TOP = KW'(LEVELS - 1);

    function automatic logic [31:0] blocks_of(input logic [KW-1:0] k);
        return TB32 << (5'(LEVELS - 1) - 5'(k));
    endfunction

    function automatic logic link_ok(input logic [KW-1:0] k, input logic [LW-1:0] v);
        return (v != '0) && (32'(v) <= blocks_of(k));
    endfunction

    state_t          state_reg, state_next;
    logic            op_reg, op_next;
    logic [4:0]      ord_reg, ord_next;
    logic [31:0]     addr_reg, addr_next;
    logic [KW-1:0]   k_reg, k_next;
    logic [NW-1:0]   base_reg, base_next;
    logic [LW-1:0]   pos_reg, pos_next;
    logic            split_reg, split_next;
    logic [LW-1:0]   hd_reg, hd_next;
    logic [LW-1:0]   pv_reg, pv_next;
    logic [PAW-1:0]  cnt_reg, cnt_next;
    logic [LW-1:0]   heads_reg [LEVELS];
    logic            head_we;
    logic [LW-1:0]   head_wdata;
    res_t            res_reg, res_next;

    logic [LW-1:0]   head_k, push_pos, opnd;
    logic            ok_head, ok_rd_next, ok_rd_prev, ok_hd, k_top, k_is_ord;
    logic            ord_bad, borrow, new_bit, cnt_last, pos_bad;
    logic [32:0]     diff;
    logic [31:0]     pos32, cnt32;
    logic [5:0]      ord_shamt;
    logic [NW-1:0]   base_init;

    assign head_k     = heads_reg[k_reg];
    assign push_pos   = pos_reg | LW'(op_reg == OP_ALLOC);
    assign ok_head    = link_ok(k_reg, head_k);
    assign ok_rd_next = link_ok(k_reg, next_rdata);
    assign ok_rd_prev = link_ok(k_reg, prev_rdata);
    assign ok_hd      = link_ok(k_reg, hd_reg);
    assign k_top      = (k_reg == K_TOP);
    assign k_is_ord   = (k_reg == ord_reg[KW-1:0]);
    assign ord_bad    = (ord_reg >= 5'(LEVELS));
    assign diff       = {1'b0, addr_reg} - {1'b0, memory_base};
    assign borrow     = diff[32];
    assign ord_shamt  = 6'(PAGE_SHIFT) + {1'b0, ord_reg};
    assign pos32      = addr_reg >> ord_shamt;
    assign pos_bad    = (pos32 >= blocks_of(ord_reg[KW-1:0]));
    assign base_init  = NW'(TBL32 - (TB32 << (5'(LEVELS) - ord_reg)));
    assign new_bit    = ~pair_rdata;
    assign cnt_last   = (cnt_reg == PAW'(PAIRS - 1));
    assign cnt32      = 32'(cnt_reg);
    assign node_addr  = base_reg + NW'(opnd);

    assign s_ready    = (state_reg == ST_IDLE);
    assign res_valid  = (state_reg == ST_DONE);
    assign res        = res_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:  if (cnt_last) state_next = ST_IDLE;
            ST_IDLE:  if (s_valid) state_next = ST_CHECK;
            ST_CHECK: begin
                if (ord_bad) begin
                    state_next = ST_DONE;
                end else if (op_reg == OP_ALLOC) begin
                    state_next = ST_SRCH;
                end else if (borrow) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_FPOS;
                end
            end
            ST_SRCH: begin
                if (ok_head) begin
                    state_next = ST_POPRD;
                end else if (k_top) begin
                    state_next = ST_DONE;
                end
            end
            ST_POPRD: state_next = ST_POPWR;
            ST_POPWR: state_next = ST_TGRD;
            ST_TGRD:  state_next = ST_TGWR;
            ST_TGWR: begin
                if (op_reg == OP_ALLOC) begin
                    state_next = split_reg ? ST_PUSH : ST_DESC;
                end else begin
                    state_next = (new_bit || k_top) ? ST_PUSH : ST_ULRD;
                end
            end
            ST_PUSH:  state_next = ST_PUSH2;
            ST_PUSH2: state_next = (op_reg == OP_ALLOC) ? ST_DESC : ST_DONE;
            ST_ULRD:  state_next = ST_ULWR1;
            ST_ULWR1: state_next = ST_ULWR2;
            ST_ULWR2: state_next = ST_TGRD;
            ST_DESC:  state_next = k_is_ord ? ST_DONE : ST_TGRD;
            ST_FPOS:  state_next = pos_bad ? ST_DONE : ST_TGRD;
            ST_DONE:  if (res_ready) state_next = ST_IDLE;
            default:  state_next = ST_INIT;
        endcase
    end

    // datapath and memory control
    always_comb begin
        op_next    = op_reg;
        ord_next   = ord_reg;
        addr_next  = addr_reg;
        k_next     = k_reg;
        base_next  = base_reg;
        pos_next   = pos_reg;
        split_next = split_reg;
        hd_next    = hd_reg;
        pv_next    = pv_reg;
        cnt_next   = cnt_reg;
        res_next   = res_reg;
        head_we    = 1'b0;
        head_wdata = '0;
        opnd       = pos_reg;
        pair_addr  = node_addr[PAW:1];
        next_wdata = '0;
        prev_wdata = '0;
        ctl        = '0;
        unique case (state_reg)
            ST_INIT: begin
                opnd           = LW'(cnt_reg);
                pair_addr      = cnt_reg;
                cnt_next       = cnt_reg + PAW'(1);
                ctl.pair_we    = 1'b1;
                ctl.pair_wdata = 1'b0;
                if (cnt32 < TB32) begin
                    ctl.next_we = 1'b1;
                    ctl.prev_we = 1'b1;
                    next_wdata = (cnt32 >= 32'd1 && cnt32 + 32'd2 < TB32)
                                 ? LW'(cnt32 + 32'd2) : '0;
                    prev_wdata = (cnt32 > 32'd1 && cnt32 + 32'd1 < TB32)
                                 ? LW'(cnt32) : '0;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    op_next   = s_data.op;
                    ord_next  = s_data.order;
                    addr_next = s_data.address;
                end
            end
            ST_CHECK: begin
                res_next   = '{addr: '0, add_base: 1'b0, status: STAT_BAD};
                base_next  = base_init;
                k_next     = ord_reg[KW-1:0];
                addr_next  = diff[31:0];
                split_next = 1'b0;
            end
            ST_SRCH: begin
                if (ok_head) begin
                    pos_next = head_k - LW'(1);
                end else if (k_top) begin
                    res_next.status = STAT_EMPTY;
                end else begin
                    base_next = base_reg + NW'(blocks_of(k_reg));
                    k_next    = k_reg + KW'(1);
                end
            end
            ST_POPRD: opnd = pos_reg;
            ST_POPWR: begin
                opnd       = next_rdata - LW'(1);
                head_we    = 1'b1;
                head_wdata = next_rdata;
                ctl.prev_we = ok_rd_next;
            end
            ST_TGRD: opnd = pos_reg;
            ST_TGWR: begin
                opnd           = pos_reg;
                ctl.pair_we    = 1'b1;
                ctl.pair_wdata = new_bit;
            end
            ST_PUSH: begin
                opnd        = push_pos;
                next_wdata  = head_k;
                ctl.next_we = 1'b1;
                ctl.prev_we = 1'b1;
                hd_next     = head_k;
            end
            ST_PUSH2: begin
                opnd        = hd_reg - LW'(1);
                prev_wdata  = push_pos + LW'(1);
                ctl.prev_we = ok_hd;
                head_we     = 1'b1;
                head_wdata  = push_pos + LW'(1);
                if (op_reg == OP_FREE) begin
                    res_next.status = STAT_OK;
                end
            end
            ST_ULRD: opnd = pos_reg ^ LW'(1);
            ST_ULWR1: begin
                opnd       = prev_rdata - LW'(1);
                next_wdata = next_rdata;
                hd_next    = next_rdata;
                pv_next    = prev_rdata;
                if (ok_rd_prev) begin
                    ctl.next_we = 1'b1;
                end else begin
                    head_we    = 1'b1;
                    head_wdata = next_rdata;
                end
            end
            ST_ULWR2: begin
                opnd        = hd_reg - LW'(1);
                prev_wdata  = pv_reg;
                ctl.prev_we = ok_hd;
                pos_next    = pos_reg >> 1;
                base_next   = base_reg + NW'(blocks_of(k_reg));
                k_next      = k_reg + KW'(1);
            end
            ST_DESC: begin
                if (k_is_ord) begin
                    res_next = '{addr: 32'(pos_reg) << ord_shamt, add_base: 1'b1,
                                 status: STAT_OK};
                end else begin
                    base_next  = base_reg - NW'(blocks_of(k_reg - KW'(1)));
                    k_next     = k_reg - KW'(1);
                    pos_next   = pos_reg << 1;
                    split_next = 1'b1;
                end
            end
            ST_FPOS: pos_next = LW'(pos32);
            ST_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            cnt_reg   <= '0;
            base_reg  <= TOP_BASE;
            for (int i = 0; i < LEVELS; i++) begin
                heads_reg[i] <= (i == LEVELS - 1) ? LW'(2) : '0;
            end
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            base_reg  <= base_next;
            if (head_we) begin
                heads_reg[k_reg] <= head_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        ord_reg   <= ord_next;
        addr_reg  <= addr_next;
        k_reg     <= k_next;
        pos_reg   <= pos_next;
        split_reg <= split_next;
        hd_reg    <= hd_next;
        pv_reg    <= pv_next;
        res_reg   <= res_next;
    end

endmodule

`default_nettype wire

FILE: bench/tb.sv
// tb: self-checking bench for buddy_page_allocator, a directed table then random alloc/free words
// checked against an in-bench free-list and pair-bit predictor
// depends on bpa_pkg and buddy_page_allocator
`default_nettype none

module tb;
    import bpa_pkg::*;

    localparam int L      = LEVELS_DEF;
    localparam int TOPN   = TOP_BLOCKS_DEF;
    localparam int PSH    = PAGE_SHIFT_DEF;
    localparam int NODES  = TOPN * ((1 << L) - 1);
    localparam int PAIRS  = NODES / 2;
    localparam int LIMIT  = 10000;
    localparam int NRAND  = 205;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    buddy_page_allocator DUT (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // predictor state
    logic [31:0] base_reg;
    logic [11:0] nxt [NODES];
    logic [11:0] prv [NODES];
    bit          wr_ok [NODES];
    logic [11:0] heads [L];
    bit          pairs [PAIRS];
    bit          touched_unwritten;

    logic [11:0] nxt_sv [NODES];
    logic [11:0] prv_sv [NODES];
    bit          wr_sv [NODES];
    logic [11:0] heads_sv [L];
    bit          pairs_sv [PAIRS];

    out_word_t   pending_words [$];
    logic [31:0] held_offs [$];
    int          held_orders [$];
    int          err_count = 0;
    int          words_in = 0;
    int          words_out = 0;
    int          n_empty = 0;
    int          n_bad = 0;
    int          s_idle_pct = 0;
    int          m_idle_pct = 0;
    int          stall_cnt = 0;

    function automatic int blocks_at(int k);
        return TOPN << (L - 1 - k);
    endfunction

    function automatic int base_at(int k);
        return TOPN * ((1 << L) - (1 << (L - k)));
    endfunction

    function automatic bit link_live(int k, int v);
        return v != 0 && v <= blocks_at(k);
    endfunction

    function automatic int rd_next(int i);
        if (!wr_ok[i]) touched_unwritten = 1'b1;
        return int'(nxt[i]);
    endfunction

    function automatic int rd_prev(int i);
        if (!wr_ok[i]) touched_unwritten = 1'b1;
        return int'(prv[i]);
    endfunction

    function automatic bit flip_pair(int k, int pos);
        int i;
        i = base_at(k) / 2 + (pos >> 1);
        pairs[i] = !pairs[i];
        return pairs[i];
    endfunction

    function automatic void push_free(int k, int pos);
        int off, h;
        off = base_at(k);
        h = int'(heads[k]);
        nxt[off + pos] = 12'(h);
        prv[off + pos] = '0;
        wr_ok[off + pos] = 1'b1;
        if (link_live(k, h)) prv[off + h - 1] = 12'(pos + 1);
        heads[k] = 12'(pos + 1);
    endfunction

    function automatic void unlink_free(int k, int pos);
        int off, p, n;
        off = base_at(k);
        p = rd_prev(off + pos);
        n = rd_next(off + pos);
        if (link_live(k, p)) nxt[off + p - 1] = 12'(n);
        else heads[k] = 12'(n);
        if (link_live(k, n)) prv[off + n - 1] = 12'(p);
    endfunction

    function automatic void reset_lists();
        int off;
        off = base_at(L - 1);
        base_reg = '0;
        for (int i = 0; i < NODES; i++) begin
            nxt[i] = '0;
            prv[i] = '0;
            wr_ok[i] = (i >= off);
        end
        for (int i = 0; i < PAIRS; i++) pairs[i] = 1'b0;
        for (int k = 0; k < L; k++) heads[k] = '0;
        for (int i = 1; i + 1 < TOPN; i++) begin
            nxt[off + i] = (i + 2 < TOPN) ? 12'(i + 2) : 12'(0);
            prv[off + i] = (i > 1) ? 12'(i) : 12'(0);
        end
        heads[L - 1] = 12'(2);
    endfunction

    function automatic out_word_t allocator_step(in_word_t w);
        out_word_t r;
        int k, pos, h, ord;
        logic [31:0] rel;
        bit set;
        r.block_address = '0;
        r.status = STAT_BAD;
        ord = int'(w.order);
        if (ord >= L) return r;
        if (op_t'(w.op) == OP_ALLOC) begin
            k = ord;
            while (k < L && !link_live(k, int'(heads[k]))) k++;
            if (k >= L) begin
                r.status = STAT_EMPTY;
                return r;
            end
            pos = int'(heads[k]) - 1;
            h = rd_next(base_at(k) + pos);
            heads[k] = 12'(h);
            if (link_live(k, h)) prv[base_at(k) + h - 1] = '0;
            void'(flip_pair(k, pos));
            while (k > ord) begin
                k--;
                pos = pos << 1;
                void'(flip_pair(k, pos));
                push_free(k, pos + 1);
            end
            r.block_address = (32'(pos) << (ord + PSH)) + base_reg;
            r.status = STAT_OK;
            return r;
        end
        if (w.address < base_reg) return r;
        rel = w.address - base_reg;
        pos = int'((rel >> PSH) >> ord);
        if (pos >= blocks_at(ord)) return r;
        k = ord;
        forever begin
            set = flip_pair(k, pos);
            if (set || k == L - 1) begin
                push_free(k, pos);
                break;
            end
            unlink_free(k, pos ^ 1);
            pos = pos >> 1;
            k++;
        end
        r.status = STAT_OK;
        return r;
    endfunction

    // trial run that leaves the state untouched; 1 if the word reads a link never written
    function automatic bit reads_unwritten(in_word_t w);
        nxt_sv = nxt;
        prv_sv = prv;
        wr_sv = wr_ok;
        heads_sv = heads;
        pairs_sv = pairs;
        touched_unwritten = 1'b0;
        void'(allocator_step(w));
        nxt = nxt_sv;
        prv = prv_sv;
        wr_ok = wr_sv;
        heads = heads_sv;
        pairs = pairs_sv;
        return touched_unwritten;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch on result %0d: %s got %h expected %h", words_out, what, got, want);
        err_count++;
    endtask

    task automatic send_word(in_word_t w, bit typed, out_word_t typed_res);
        out_word_t r;
        bit acc;
        while ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_data <= w;
        s_valid <= 1'b1;
        do begin
            @(negedge aclk);
            acc = s_ready;
            @(posedge aclk);
        end while (!acc);
        r = allocator_step(w);
        if (typed) r = typed_res;
        pending_words.push_back(r);
        words_in++;
        if (r.status == STAT_EMPTY) n_empty++;
        if (r.status == STAT_BAD) n_bad++;
        if (op_t'(w.op) == OP_ALLOC && r.status == STAT_OK) begin
            held_offs.push_back(r.block_address - base_reg);
            held_orders.push_back(int'(w.order));
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic write_base(logic [31:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        base_reg = v;
        cfg_we <= 1'b0;
    endtask

    function automatic in_word_t random_word(int alloc_pct);
        in_word_t w;
        int pick, ord;
        logic [31:0] span;
        w.op = 1'b0;
        w.order = 5'($urandom_range(L - 1));
        w.address = $urandom;
        pick = $urandom_range(99);
        if (pick < alloc_pct) begin
            w.op = OP_ALLOC;
        end else if (pick < 88 && held_offs.size() != 0) begin
            pick = $urandom_range(held_offs.size() - 1);
            ord = held_orders[pick];
            span = 32'd1 << (ord + PSH);
            w.op = OP_FREE;
            w.order = 5'(ord);
            w.address = base_reg + held_offs[pick];
            if ($urandom_range(3) == 0) w.address = w.address + ($urandom % span);
            held_offs.delete(pick);
            held_orders.delete(pick);
        end else begin
            w.op = 1'($urandom_range(1));
            case ($urandom_range(4))
                0: w.order = 5'($urandom_range(31, L));
                1: w.address = base_reg - 32'($urandom_range(1, 4096));
                2: w.address = base_reg + 32'($urandom_range(TOPN << (L - 1 + PSH), 32'hFFFF_FFFF));
                3: w.address = base_reg + (32'($urandom_range(blocks_at(w.order) - 1))
                                           << (w.order + PSH));
                default: ;
            endcase
        end
        return w;
    endfunction

    typedef struct {
        logic        op;
        logic [4:0]  order;
        logic [31:0] address;
        bit          typed;
        logic [31:0] res_addr;
        stat_t       res_stat;
    } row_t;

    row_t plan [] = '{
        '{OP_ALLOC, 5'd7,  32'h0,         1, 32'h0008_0000, STAT_OK},
        '{OP_ALLOC, 5'd8,  32'h0,         1, 32'h0,         STAT_BAD},
        '{OP_FREE,  5'd31, 32'h0008_0000, 1, 32'h0,         STAT_BAD},
        '{OP_FREE,  5'd7,  32'hFFFF_FFFF, 1, 32'h0,         STAT_BAD},
        '{OP_ALLOC, 5'd0,  32'hFFFF_FFFF, 0, 32'h0,         STAT_OK},
        '{OP_ALLOC, 5'd0,  32'h0,         0, 32'h0,         STAT_OK},
        '{OP_FREE,  5'd0,  32'h0010_0FFF, 0, 32'h0,         STAT_OK},
        '{OP_FREE,  5'd0,  32'h0010_1000, 0, 32'h0,         STAT_OK},
        '{OP_FREE,  5'd7,  32'h0008_0000, 0, 32'h0,         STAT_OK},
        '{OP_ALLOC, 5'd3,  32'h0,         0, 32'h0,         STAT_OK},
        '{OP_ALLOC, 5'd6,  32'h0,         0, 32'h0,         STAT_OK},
        '{OP_FREE,  5'd6,  32'h0,         0, 32'h0,         STAT_OK},
        '{OP_FREE,  5'd7,  32'h0078_0000, 0, 32'h0,         STAT_OK},
        '{OP_ALLOC, 5'd7,  32'h0,         0, 32'h0,         STAT_OK},
        '{OP_ALLOC, 5'd7,  32'h0,         0, 32'h0,         STAT_OK},
        '{OP_ALLOC, 5'd7,  32'h0,         0, 32'h0,         STAT_OK},
        '{OP_ALLOC, 5'd7,  32'h0,         0, 32'h0,         STAT_OK},
        '{OP_ALLOC, 5'd7,  32'h0,         0, 32'h0,         STAT_OK},
        '{OP_ALLOC, 5'd7,  32'h0,         0, 32'h0,         STAT_OK},
        '{OP_ALLOC, 5'd7,  32'h0,         0, 32'h0,         STAT_OK},
        '{OP_ALLOC, 5'd7,  32'h0,         0, 32'h0,         STAT_OK},
        '{OP_ALLOC, 5'd7,  32'h0,         0, 32'h0,         STAT_OK},
        '{OP_ALLOC, 5'd7,  32'h0,         0, 32'h0,         STAT_OK},
        '{OP_ALLOC, 5'd7,  32'h0,         0, 32'h0,         STAT_OK},
        '{OP_ALLOC, 5'd7,  32'h0,         0, 32'h0,         STAT_OK}
    };

    logic [31:0] base_plan [6] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0040_0000,
                                   32'h0, 32'hFFF0_0000, 32'h8000_0000};

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= m_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_words.size() == 0) begin
                report_mismatch("unexpected word", m_data.block_address, 32'h0);
            end else begin
                out_word_t want;
                want = pending_words.pop_front();
                if (m_data.block_address !== want.block_address)
                    report_mismatch("block_address", m_data.block_address, want.block_address);
                if (m_data.status !== want.status)
                    report_mismatch("status", 32'(m_data.status), 32'(want.status));
            end
            words_out++;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cnt <= 0;
        else stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        in_word_t  w;
        out_word_t t;
        base_plan[3] = $urandom & 32'hFFFF_F000;
        reset_lists();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (plan[i]) begin
            w.op = plan[i].op;
            w.order = plan[i].order;
            w.address = plan[i].address;
            t.block_address = plan[i].res_addr;
            t.status = plan[i].res_stat;
            send_word(w, plan[i].typed, t);
        end
        for (int ph = 0; ph < 6; ph++) begin
            s_idle_pct = (ph < 2) ? 14 : (ph < 4) ? 72 : 0;
            m_idle_pct = (ph < 2) ? 72 : (ph < 4) ? 14 : 0;
            write_base(base_plan[ph]);
            for (int n = 0; n < NRAND; n++) begin
                if (n == NRAND / 2) drain();
                do w = random_word((ph % 2) ? 62 : 45);
                while (reads_unwritten(w));
                send_word(w, 1'b0, t);
            end
        end
        drain();
        $display("%0d words sent, %0d results checked (%0d out of blocks, %0d rejected)",
                 words_in, words_out, n_empty, n_bad);
        $display("six base settings, sender and receiver stalls both ways and back to back");
        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

`default_nettype wire

FILE: files.f
rtl/core/bpa_pkg.sv
rtl/core/bpa_mem.sv
rtl/core/bpa_ctrl.sv
rtl/core/buddy_page_allocator.sv
bench/tb.sv
